[src/cpr_pkg.sv]
// Package: shared constants and types for the clock page replacement block.
`timescale 1ns / 1ps
`default_nettype none
package cpr_pkg;

	localparam int SLOTS_DEF     = 8;
	localparam int PAGE_BITS_DEF = 20;
	localparam int START_W       = 3;
	localparam int SLOT_FIELD_W  = 3;

	typedef struct packed {
		logic                    hit;
		logic [SLOT_FIELD_W-1:0] slot;
		logic                    evicted;
	} res_flags_t;

endpackage
`default_nettype wire

[src/cpr_core.sv]
// Core: slot page memory, valid and use flags, lookup scan and clock sweep sequencer.
`timescale 1ns / 1ps
`default_nettype none
module cpr_core #(
	parameter int SLOTS     = cpr_pkg::SLOTS_DEF,
	parameter int PAGE_BITS = cpr_pkg::PAGE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [PAGE_BITS-1:0]          in_page,
	input  wire logic [cpr_pkg::START_W-1:0]   in_start,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output cpr_pkg::res_flags_t                res_flags,
	output logic [PAGE_BITS-1:0]               res_evicted_page
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
	localparam int START_REDUCE_STEPS = (1 << cpr_pkg::START_W) / 2;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_LOOK  = 2'd1;
	localparam logic [1:0] ST_SWEEP = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]           state_q;
	logic [PAGE_BITS-1:0] page_q;
	logic [IDX_W-1:0]     start_q;
	logic [IDX_W-1:0]     scan_q;
	logic                 scan_done_q;
	logic                 cmp_vld_s1;
	logic [IDX_W-1:0]     cmp_idx_s1;
	logic                 have_empty_q;
	logic [IDX_W-1:0]     empty_q;
	logic [IDX_W-1:0]     sw_q;
	logic [IDX_W-1:0]     target_q;
	logic                 hit_q;
	logic                 ev_q;
	logic [SLOTS-1:0]     valid_q;
	logic [SLOTS-1:0]     use_q;

	logic [PAGE_BITS-1:0] mem [SLOTS];
	logic [PAGE_BITS-1:0] rd_q;
	logic [IDX_W-1:0]     rd_addr;
	logic                 mem_we;
	logic                 cmp_hit;
	logic                 fin_go;
	logic [IDX_W-1:0]     start_mod;
	logic [cpr_pkg::START_W-1:0] start_red;

	// reduce the start slot below SLOTS by repeated compare and subtract
	always_comb begin
		start_red = in_start;
		for (int i = 0; i < START_REDUCE_STEPS; i++) begin
			if (32'(start_red) >= SLOTS) begin
				start_red = start_red - cpr_pkg::START_W'(SLOTS);
			end
		end
	end

	assign start_mod = IDX_W'(start_red);
	assign cmp_hit   = cmp_vld_s1 && valid_q[cmp_idx_s1] && (rd_q == page_q);
	assign fin_go    = (state_q == ST_FIN) && res_ready;
	assign mem_we    = fin_go && !hit_q;
	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_FIN);

	always_comb begin
		case (state_q)
			ST_LOOK:  rd_addr = scan_q;
			ST_SWEEP: rd_addr = sw_q;
			ST_FIN:   rd_addr = target_q;
			default:  rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[target_q] <= page_q;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			scan_q       <= '0;
			scan_done_q  <= 1'b0;
			cmp_vld_s1   <= 1'b0;
			cmp_idx_s1   <= '0;
			have_empty_q <= 1'b0;
			empty_q      <= '0;
			sw_q         <= '0;
			target_q     <= '0;
			hit_q        <= 1'b0;
			ev_q         <= 1'b0;
			valid_q      <= '0;
			use_q        <= '0;
			page_q       <= '0;
			start_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						page_q       <= in_page;
						start_q      <= start_mod;
						scan_q       <= '0;
						scan_done_q  <= 1'b0;
						cmp_vld_s1   <= 1'b0;
						have_empty_q <= 1'b0;
						state_q      <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					// issue one read per cycle, compare against the registered read data
					cmp_idx_s1 <= scan_q;
					if (!scan_done_q) begin
						if (!valid_q[scan_q] && !have_empty_q) begin
							have_empty_q <= 1'b1;
							empty_q      <= scan_q;
						end
						if (scan_q == LAST_IDX) begin
							scan_done_q <= 1'b1;
						end else begin
							scan_q <= scan_q + 1'b1;
						end
					end
					if (cmp_hit) begin
						cmp_vld_s1 <= 1'b0;
						hit_q      <= 1'b1;
						ev_q       <= 1'b0;
						target_q   <= cmp_idx_s1;
						state_q    <= ST_FIN;
					end else if (cmp_vld_s1 && cmp_idx_s1 == LAST_IDX) begin
						cmp_vld_s1 <= 1'b0;
						hit_q      <= 1'b0;
						if (have_empty_q) begin
							ev_q     <= 1'b0;
							target_q <= empty_q;
							state_q  <= ST_FIN;
						end else begin
							sw_q    <= start_q;
							state_q <= ST_SWEEP;
						end
					end else begin
						cmp_vld_s1 <= !scan_done_q;
					end
				end
				ST_SWEEP: begin
					if (use_q[sw_q]) begin
						use_q[sw_q] <= 1'b0;
						sw_q        <= (sw_q == LAST_IDX) ? '0 : sw_q + 1'b1;
					end else begin
						ev_q     <= 1'b1;
						target_q <= sw_q;
						state_q  <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (res_ready) begin
						valid_q[target_q] <= 1'b1;
						use_q[target_q]   <= 1'b1;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_flags.hit     = hit_q;
	assign res_flags.slot    = cpr_pkg::SLOT_FIELD_W'(target_q);
	assign res_flags.evicted = ev_q;
	assign res_evicted_page  = ev_q ? rd_q : '0;

	a_sweep_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> (&valid_q))
		else $error("sweep entered with an empty slot");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && hit_q) |-> !ev_q)
		else $error("hit reported with eviction");

	a_fin_marks: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> (use_q[$past(target_q)] && valid_q[$past(target_q)]))
		else $error("target slot not marked after transfer");

	a_evict_victim_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && !use_q[sw_q]) |=> (state_q == ST_FIN && ev_q))
		else $error("sweep missed a clear use bit");

endmodule
`default_nettype wire

[src/clock_page_replacement.sv]
// Top level: stream ports and result register around the clock replacement core.
`timescale 1ns / 1ps
`default_nettype none
// Clock (second chance) page replacement over SLOTS resident slots. Each input transfer carries
// a page number and a sweep start slot and yields exactly one result transfer. A hit ends the
// lookup early when the page sits in a low slot, a fill of an empty slot ends after the lookup
// pass, and a miss with no empty slot goes on to a sweep: the single-port page memory is read
// one slot per cycle, first for the lookup pass and then for the clock sweep. The input is not
// ready while an item is in work. The result sits in an output register, so the next item is
// taken while the previous result waits; a second result holds the core until the first leaves.
module clock_page_replacement #(
	parameter int SLOTS     = cpr_pkg::SLOTS_DEF,
	parameter int PAGE_BITS = cpr_pkg::PAGE_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// page_number, start_slot, zero fill
	input  wire logic [((PAGE_BITS + cpr_pkg::START_W + 7) / 8) * 8 - 1:0] s_tdata,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// hit, slot, evicted, evicted_page, zero fill
	output logic [((PAGE_BITS + cpr_pkg::SLOT_FIELD_W + 2 + 7) / 8) * 8 - 1:0] m_tdata
);

	localparam int IN_W  = ((PAGE_BITS + cpr_pkg::START_W + 7) / 8) * 8;
	localparam int RES_W = PAGE_BITS + cpr_pkg::SLOT_FIELD_W + 2;
	localparam int OUT_W = ((RES_W + 7) / 8) * 8;

	logic                 core_in_ready;
	logic                 res_valid;
	logic                 res_ready;
	cpr_pkg::res_flags_t  res_flags;
	logic [PAGE_BITS-1:0] res_evicted_page;
	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_data_q;
	logic [IN_W-1:0]      in_data;

	assign in_data   = s_tdata;
	assign s_tready  = core_in_ready;
	assign res_ready = !out_valid_q || m_tready;

	cpr_core #(
		.SLOTS     (SLOTS),
		.PAGE_BITS (PAGE_BITS)
	) u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (s_tvalid),
		.in_ready         (core_in_ready),
		.in_page          (in_data[PAGE_BITS-1:0]),
		.in_start         (in_data[PAGE_BITS +: cpr_pkg::START_W]),
		.res_valid        (res_valid),
		.res_ready        (res_ready),
		.res_flags        (res_flags),
		.res_evicted_page (res_evicted_page)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= OUT_W'({res_evicted_page, res_flags.evicted, res_flags.slot,
				res_flags.hit});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
`default_nettype wire

[test/clock_page_replacement_tb.sv]
// Testbench: stream-driven regression of the clock page replacement block against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module clock_page_replacement_tb;

	localparam int SLOTS    = cpr_pkg::SLOTS_DEF;
	localparam int PAGE_W   = cpr_pkg::PAGE_BITS_DEF;
	localparam int START_W  = cpr_pkg::START_W;
	localparam int SLOT_W   = cpr_pkg::SLOT_FIELD_W;
	localparam int IN_W     = ((PAGE_W + START_W + 7) / 8) * 8;
	localparam int OUT_W    = ((PAGE_W + SLOT_W + 2 + 7) / 8) * 8;
	localparam int HIT_LSB  = 0;
	localparam int SLOT_LSB = 1;
	localparam int EVT_LSB  = SLOT_LSB + SLOT_W;
	localparam int EVP_LSB  = EVT_LSB + 1;
	localparam int RANDOM_ACCESSES = 1950;
	localparam int STALL_LIMIT     = 4000;
	localparam int DRAIN_CYCLES    = 40;

	typedef logic [PAGE_W-1:0]  page_t;
	typedef logic [START_W-1:0] start_t;

	typedef struct {
		cpr_pkg::res_flags_t flags;
		page_t               evicted_page;
	} access_result_t;

	class page_table_model;
		page_t          resident_page [SLOTS];
		bit             resident_valid[SLOTS];
		bit             use_bit       [SLOTS];
		access_result_t pending_results[$];
		int             mismatches;
		int             hits;
		int             fills;
		int             evictions;

		function void note_access(page_t page, start_t start);
			access_result_t r;
			int             victim;
			int             idx;
			victim = -1;
			r.flags = '0;
			r.evicted_page = '0;
			for (int k = 0; k < SLOTS; k++) begin
				if (resident_valid[k] && resident_page[k] == page) begin
					victim = k;
					break;
				end
			end
			if (victim >= 0) begin
				use_bit[victim] = 1'b1;
				r.flags.hit = 1'b1;
				hits++;
			end else begin
				for (int k = 0; k < SLOTS; k++) begin
					if (!resident_valid[k]) begin
						victim = k;
						break;
					end
				end
				if (victim >= 0) begin
					fills++;
				end else begin
					victim = int'(start) % SLOTS;
					for (int k = 0; k < SLOTS; k++) begin
						idx = (int'(start) + k) % SLOTS;
						if (!use_bit[idx]) begin
							victim = idx;
							break;
						end
						use_bit[idx] = 1'b0;
					end
					r.flags.evicted = 1'b1;
					r.evicted_page = resident_page[victim];
					evictions++;
				end
				resident_page[victim] = page;
				resident_valid[victim] = 1'b1;
				use_bit[victim] = 1'b1;
			end
			r.flags.slot = SLOT_W'(victim);
			pending_results.push_back(r);
		endfunction

		function void check_result(logic [OUT_W-1:0] word);
			access_result_t want;
			if (pending_results.size() == 0) begin
				$error("result with no access pending: %h", word);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			if (word[HIT_LSB] !== want.flags.hit) begin
				$error("hit: expected %0d, got %0d", want.flags.hit, word[HIT_LSB]);
				mismatches++;
			end
			if (word[SLOT_LSB+:SLOT_W] !== want.flags.slot) begin
				$error("slot: expected %0d, got %0d", want.flags.slot, word[SLOT_LSB+:SLOT_W]);
				mismatches++;
			end
			if (word[EVT_LSB] !== want.flags.evicted) begin
				$error("evicted: expected %0d, got %0d", want.flags.evicted, word[EVT_LSB]);
				mismatches++;
			end
			if (word[EVP_LSB+:PAGE_W] !== want.evicted_page) begin
				$error("evicted_page: expected %h, got %h", want.evicted_page,
					word[EVP_LSB+:PAGE_W]);
				mismatches++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	page_table_model model = new;
	bit              calm = 1'b0;
	int              quiet_cycles = 0;
	page_t           working_set[16];
	int              span;

	clock_page_replacement uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("clock_page_replacement regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			m_tready <= calm || ($urandom_range(99) >= 28);
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				model.check_result(m_tdata);
			end
		end
	end

	task automatic send_access(input page_t page, input start_t start);
		logic [IN_W-1:0] word;
		word = '0;
		word[PAGE_W-1:0] = page;
		word[PAGE_W+:START_W] = start;
		while (!calm && $urandom_range(99) < 28) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
		model.note_access(page, start);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (model.pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// page zero fills, then hits; all-ones page; fill the rest
		send_access(20'h00000, 3'd0);
		send_access(20'h00000, 3'd7);
		send_access(20'hFFFFF, 3'd7);
		for (int k = 1; k < SLOTS - 1; k++) begin
			send_access(page_t'(k), start_t'(k));
		end
		send_access(20'hFFFFF, 3'd3);
		// every use bit set: full sweep, start slot taken
		send_access(20'h80000, 3'd0);
		send_access(20'h00010, 3'd7);
		send_access(20'h80000, 3'd2);
		send_access(20'h00001, 3'd5);
		send_access(20'h7FFFF, 3'd5);
		send_access(20'h55555, 3'd4);
		send_access(20'hAAAAA, 3'd6);
		send_access(20'h00000, 3'd1);
		send_access(20'h00000, 3'd1);

		for (int k = 0; k < 16; k++) begin
			working_set[k] = page_t'($urandom);
		end
		span = 10;
		for (int n = 0; n < RANDOM_ACCESSES; n++) begin
			calm = (n >= 600 && n < 900);
			if (n % 150 == 0) begin
				span = $urandom_range(16, 5);
			end
			if ($urandom_range(99) < 3) begin
				working_set[$urandom_range(15)] = page_t'($urandom);
			end
			if (n == 1000) begin
				drain_results();
			end
			if ($urandom_range(99) < 85) begin
				send_access(working_set[$urandom_range(span - 1)], start_t'($urandom));
			end else begin
				send_access(page_t'($urandom), start_t'($urandom));
			end
		end
		calm = 1'b0;
		drain_results();

		$display("covered %0d accesses: %0d hits, %0d empty-slot fills, %0d evictions",
			model.hits + model.fills + model.evictions, model.hits, model.fills,
			model.evictions);
		if (model.mismatches == 0) begin
			$display("clock_page_replacement regression: pass");
		end else begin
			$display("clock_page_replacement regression: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire
